@@ hw/rtl/cruw_pkg.sv @@
// Shared types and constants for the command ring update writer.
// No dependencies; every other file in hw/rtl imports this package.
package cruw_pkg;

   localparam int RING_BYTES      = 4096;
   localparam int SCREEN_WIDTH    = 1024;
   localparam int SCREEN_HEIGHT   = 768;
   localparam int MAX_AREA        = 4096;
   localparam int NEED_BYTES      = 24;
   localparam int RING_START_MIN  = 16;
   localparam int RING_START_MAX  = RING_BYTES - NEED_BYTES;
   localparam int CMD_WORDS       = 5;
   localparam int WORD_BYTES      = 4;

   localparam int OFFSET_W        = 12;
   localparam int COORD_W         = 16;
   localparam int INDEX_W         = 10;
   localparam int DATA_W          = 32;
   localparam int STEP_W          = $clog2(CMD_WORDS + 1);

   localparam int REQ_TDATA_W     = 80;
   localparam int RSP_TDATA_W     = 48;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [OFFSET_W-1:0] RESET_OFFSET = OFFSET_W'(16);
   localparam logic [DATA_W-1:0]   OPCODE_UPDATE = DATA_W'(1);
   localparam logic [INDEX_W-1:0]  WRITE_OFFSET_WORD = INDEX_W'(2);

   // register index within the CSR space (word address)
   localparam logic REG_RING_START = 1'b0;

   localparam logic KIND_UPDATE  = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_INVALID_ARG = 2'd1,
      ST_PTR_CORRUPT = 2'd2,
      ST_NO_SPACE    = 2'd3
   } status_type;

   // One classified item handed from the front end to the back end.
   typedef struct packed {
      status_type                status;
      logic                      publish_cmd;
      logic [COORD_W-1:0]        rect_x;
      logic [COORD_W-1:0]        rect_y;
      logic [COORD_W-1:0]        rect_width;
      logic [COORD_W-1:0]        rect_height;
      logic [OFFSET_W-1:0]       start_offset;
      logic [OFFSET_W-1:0]       next_offset;
      logic [OFFSET_W-1:0]       ring_start;
   } desc_type;

endpackage

@@ hw/rtl/cruw_front.sv @@
// Front end: accepts request items, runs all validity and space checks,
// owns the producer write offset. Depends on cruw_pkg.
module cruw_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_kind,
   input  logic [cruw_pkg::COORD_W-1:0]    req_rect_x,
   input  logic [cruw_pkg::COORD_W-1:0]    req_rect_y,
   input  logic [cruw_pkg::COORD_W-1:0]    req_rect_width,
   input  logic [cruw_pkg::COORD_W-1:0]    req_rect_height,
   input  logic                            req_publish,
   input  logic [cruw_pkg::OFFSET_W-1:0]   req_read_offset,
   input  logic [cruw_pkg::OFFSET_W-1:0]   ring_start,
   input  logic                            q_full,
   output logic                            q_push,
   output cruw_pkg::desc_type              q_desc
);
   import cruw_pkg::*;

   localparam int W13 = OFFSET_W + 1;
   localparam int W14 = OFFSET_W + 2;
   localparam int WC  = COORD_W + 1;

   logic [OFFSET_W-1:0] write_offset_ff, write_offset_in;
   logic [W13-1:0]      rs13, wr13, rd13, sum13;
   logic [W14-1:0]      wrap_avail;
   logic [2*COORD_W-1:0] area;
   logic                rs_bad, rect_bad, off_bad, space_bad, accept;
   logic [OFFSET_W-1:0] next_offset;
   status_type          status;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   assign rs13 = {1'b0, ring_start};
   assign wr13 = {1'b0, write_offset_ff};
   assign rd13 = {1'b0, req_read_offset};

   assign rs_bad = (rs13 < W13'(RING_START_MIN)) || (rs13 > W13'(RING_START_MAX)) ||
                   (ring_start[1:0] != 2'b00);

   assign area = req_rect_width * req_rect_height;

   assign rect_bad = (req_rect_width == '0) || (req_rect_height == '0) ||
                     (req_rect_width > COORD_W'(SCREEN_WIDTH)) ||
                     (req_rect_height > COORD_W'(SCREEN_HEIGHT)) ||
                     (({1'b0, req_rect_x} + {1'b0, req_rect_width}) > WC'(SCREEN_WIDTH)) ||
                     (({1'b0, req_rect_y} + {1'b0, req_rect_height}) > WC'(SCREEN_HEIGHT)) ||
                     (area > (2*COORD_W)'(MAX_AREA));

   assign off_bad = (wr13 < rs13) || (wr13 >= W13'(RING_BYTES)) ||
                    (write_offset_ff[1:0] != 2'b00) ||
                    (rd13 < rs13) || (rd13 >= W13'(RING_BYTES)) ||
                    (req_read_offset[1:0] != 2'b00);

   // wrapped free space; offsets already checked to lie in the ring
   assign wrap_avail = W14'(RING_BYTES) - {1'b0, wr13} + {1'b0, rd13} - {1'b0, rs13};

   always_comb begin
      if (rd13 > wr13) begin
         space_bad = (rd13 - wr13) < W13'(NEED_BYTES);
      end else begin
         space_bad = wrap_avail < W14'(NEED_BYTES);
      end
   end

   always_comb begin
      if (rs_bad || rect_bad) begin
         status = ST_INVALID_ARG;
      end else if (off_bad) begin
         status = ST_PTR_CORRUPT;
      end else if (space_bad) begin
         status = ST_NO_SPACE;
      end else begin
         status = ST_OK;
      end
   end

   // offset after five words; wraps at most once since the ring holds 24+ bytes
   assign sum13 = wr13 + W13'(CMD_WORDS * WORD_BYTES);
   always_comb begin
      if (sum13 >= W13'(RING_BYTES)) begin
         next_offset = OFFSET_W'(rs13 + (sum13 - W13'(RING_BYTES)));
      end else begin
         next_offset = sum13[OFFSET_W-1:0];
      end
   end

   always_comb begin
      q_desc.status       = (req_kind == KIND_RESTART) ? ST_OK : status;
      q_desc.publish_cmd  = (req_kind == KIND_UPDATE) && req_publish && (status == ST_OK);
      q_desc.rect_x       = req_rect_x;
      q_desc.rect_y       = req_rect_y;
      q_desc.rect_width   = req_rect_width;
      q_desc.rect_height  = req_rect_height;
      q_desc.start_offset = write_offset_ff;
      q_desc.next_offset  = next_offset;
      q_desc.ring_start   = ring_start;
   end

   assign q_push = accept;

   always_comb begin
      write_offset_in = write_offset_ff;
      if (accept) begin
         if (req_kind == KIND_RESTART) begin
            write_offset_in = ring_start;
         end else if (q_desc.publish_cmd) begin
            write_offset_in = next_offset;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_offset_ff <= RESET_OFFSET;
      end else begin
         write_offset_ff <= write_offset_in;
      end
   end

endmodule

@@ hw/rtl/cruw_queue.sv @@
// Short queue of classified items between front and back end.
// Depends on cruw_pkg for the item type.
module cruw_queue #(
   parameter int DEPTH = cruw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cruw_pkg::desc_type   push_desc,
   input  logic                 pop,
   output cruw_pkg::desc_type   head_desc,
   output logic                 full,
   output logic                 empty
);
   import cruw_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_desc = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

@@ hw/rtl/cruw_back.sv @@
// Back end: expands each classified item into its result items, one per
// cycle while rsp_tready does not stall the output, through a registered output stage. Depends on cruw_pkg.
module cruw_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  cruw_pkg::desc_type              head_desc,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output cruw_pkg::status_type            rsp_status,
   output logic                            rsp_write_valid,
   output logic [cruw_pkg::INDEX_W-1:0]    rsp_word_index,
   output logic [cruw_pkg::DATA_W-1:0]     rsp_word_data,
   output logic                            rsp_last
);
   import cruw_pkg::*;

   localparam int W13 = OFFSET_W + 1;

   logic                  valid_ff, valid_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [OFFSET_W-1:0]   ptr_ff, ptr_in, cur;
   logic [W13-1:0]        bumped;
   status_type            status_ff, status_in;
   logic                  wv_ff, wv_in, last_ff, last_in;
   logic [INDEX_W-1:0]    index_ff, index_in;
   logic [DATA_W-1:0]     data_ff, data_in;
   logic                  load, final_step;

   assign load       = !q_empty && (!valid_ff || rsp_tready);
   assign final_step = (step_ff == STEP_W'(CMD_WORDS));
   assign q_pop      = load && (!head_desc.publish_cmd || final_step);

   assign cur    = (step_ff == '0) ? head_desc.start_offset : ptr_ff;
   assign bumped = {1'b0, cur} + W13'(WORD_BYTES);

   always_comb begin
      ptr_in = ptr_ff;
      if (load && head_desc.publish_cmd) begin
         ptr_in = (bumped == W13'(RING_BYTES)) ? head_desc.ring_start
                                               : bumped[OFFSET_W-1:0];
      end
   end

   always_comb begin
      step_in = step_ff;
      if (load && head_desc.publish_cmd) begin
         step_in = final_step ? '0 : step_ff + 1'b1;
      end
   end

   always_comb begin
      valid_in  = valid_ff && !rsp_tready;
      status_in = status_ff;
      wv_in     = wv_ff;
      index_in  = index_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in  = 1'b1;
         status_in = head_desc.status;
         if (!head_desc.publish_cmd) begin
            wv_in    = 1'b0;
            index_in = '0;
            data_in  = '0;
            last_in  = 1'b1;
         end else begin
            wv_in    = 1'b1;
            index_in = cur[OFFSET_W-1:2];
            last_in  = final_step;
            case (step_ff)
               3'd0:    data_in = OPCODE_UPDATE;
               3'd1:    data_in = DATA_W'(head_desc.rect_x);
               3'd2:    data_in = DATA_W'(head_desc.rect_y);
               3'd3:    data_in = DATA_W'(head_desc.rect_width);
               3'd4:    data_in = DATA_W'(head_desc.rect_height);
               default: data_in = DATA_W'(head_desc.next_offset);
            endcase
            if (final_step) begin
               index_in = WRITE_OFFSET_WORD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
      ptr_ff    <= ptr_in;
      status_ff <= status_in;
      wv_ff     <= wv_in;
      index_ff  <= index_in;
      data_ff   <= data_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid      = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_write_valid = wv_ff;
   assign rsp_word_index  = index_ff;
   assign rsp_word_data   = data_ff;
   assign rsp_last        = last_ff;

endmodule

@@ hw/rtl/command_ring_update_writer.sv @@
// Top level of the command ring update writer: CSR port, front end, queue
// and back end. Depends on cruw_pkg, cruw_front, cruw_queue, cruw_back.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   req     | in        | req_tvalid/req_tready  | req_tdata (rectangle, publish,
//           |           |                        |  read offset), req_tuser (kind)
//   rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata (status, write,
//           |           |                        |  index, data), rsp_tlast
//   csr     | in/out    | APB psel/penable       | ring_start at address 0
//
// Results: a rejected, check-only or restart item yields one result item;
// a published update yields six. The back end's single result register
// sends one word per cycle while rsp_tready does not stall it.
// The front end takes one item per cycle while the queue has room.
// Reset: ring_start and the write offset return to 16, queue and output empty.
// Stalls: rsp_tready low holds the output register; once the queue fills,
// req_tready drops until the back end pops an item.
module command_ring_update_writer #(
   parameter int QUEUE_DEPTH = cruw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // rect_x[15:0], rect_y[31:16], rect_width[47:32], rect_height[63:48],
   // publish[64], read_offset[76:65], zero fill [79:77]
   input  logic [cruw_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // kind[0]
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // status[1:0], write_valid[2], word_index[12:3], word_data[44:13],
   // zero fill [47:45]
   output logic [cruw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cruw_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cruw_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cruw_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import cruw_pkg::*;

   logic [OFFSET_W-1:0] ring_start_ff, ring_start_in;
   logic                csr_write;
   desc_type            push_desc, head_desc;
   logic                q_push, q_pop, q_full, q_empty;
   status_type          rsp_status;
   logic                rsp_write_valid;
   logic [INDEX_W-1:0]  rsp_word_index;
   logic [DATA_W-1:0]   rsp_word_data;

   // ---- CSR port: always ready, byte offset within the word is ignored
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      ring_start_in = ring_start_ff;
      if (csr_write && (csr_paddr[2] == REG_RING_START)) begin
         ring_start_in = csr_pwdata[OFFSET_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_RING_START) ? CSR_DATA_W'(ring_start_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_start_ff <= RESET_OFFSET;
      end else begin
         ring_start_ff <= ring_start_in;
      end
   end

   // ---- front end: classify and advance the write offset at accept time
   cruw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_kind        (req_tuser),
      .req_rect_x      (req_tdata[15:0]),
      .req_rect_y      (req_tdata[31:16]),
      .req_rect_width  (req_tdata[47:32]),
      .req_rect_height (req_tdata[63:48]),
      .req_publish     (req_tdata[64]),
      .req_read_offset (req_tdata[76:65]),
      .ring_start      (ring_start_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_desc          (push_desc)
   );

   // ---- queue: lets the front keep accepting while results drain
   cruw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .head_desc (head_desc),
      .full      (q_full),
      .empty     (q_empty)
   );

   // ---- back end: emit one result item per cycle while rsp_tready allows
   cruw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .head_desc       (head_desc),
      .q_pop           (q_pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_status      (rsp_status),
      .rsp_write_valid (rsp_write_valid),
      .rsp_word_index  (rsp_word_index),
      .rsp_word_data   (rsp_word_data),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, rsp_word_data, rsp_word_index, rsp_write_valid, rsp_status};

   // ---- checks
   // a result without a memory write always closes its item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_write_valid) |-> rsp_tlast)
      else $error("non-write result without last");

   // memory writes only come from accepted updates
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_write_valid) |-> (rsp_status == ST_OK))
      else $error("memory write with failing status");

   // queue occupancy flags are never both set
   assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue reports full and empty");

   // a popped item was present at the head
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

endmodule
